// ----- hw/rtl/usbpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbpd_pkg
// Shared types, codes and constants of the USB-PD sink policy engine.
// ----------------------------------------------------------------------------
package usbpd_pkg;

    // Largest data object count that a received header may announce.
    localparam logic [2:0] MAX_OBJECTS = 3'd7;

    // Input operation codes.
    localparam logic [1:0] OP_HEADER     = 2'd0;
    localparam logic [1:0] OP_OBJECT     = 2'd1;
    localparam logic [1:0] OP_LINK_RESET = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    // Negotiation states.
    localparam logic [1:0] NEG_NEGOTIATING = 2'd0;
    localparam logic [1:0] NEG_CONTRACT    = 2'd1;
    localparam logic [1:0] NEG_FALLBACK    = 2'd2;

    // Amplifier mode recommendations.
    localparam logic [1:0] AMP_NORMAL = 2'd0;
    localparam logic [1:0] AMP_HIGH   = 2'd2;

    // Control message types.
    localparam logic [4:0] CTRL_GOODCRC       = 5'd1;
    localparam logic [4:0] CTRL_ACCEPT        = 5'd3;
    localparam logic [4:0] CTRL_REJECT        = 5'd4;
    localparam logic [4:0] CTRL_PS_RDY        = 5'd6;
    localparam logic [4:0] CTRL_GET_SINK_CAP  = 5'd8;
    localparam logic [4:0] CTRL_WAIT          = 5'd12;
    localparam logic [4:0] CTRL_SOFT_RESET    = 5'd13;
    localparam logic [4:0] CTRL_NOT_SUPPORTED = 5'd16;

    // Data message types.
    localparam logic [4:0] DATA_SOURCE_CAP = 5'd1;
    localparam logic [4:0] DATA_REQUEST    = 5'd2;
    localparam logic [4:0] DATA_SINK_CAP   = 5'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_REQUEST_MV = 2'd0;
    localparam logic [1:0] CFG_SINK_CAP_WORD  = 2'd1;
    localparam logic [1:0] CFG_HIGH_POWER_MV  = 2'd2;

    // Reset values.
    localparam logic [15:0] MAX_REQUEST_MV_RST = 16'd20000;
    localparam logic [31:0] SINK_CAP_WORD_RST  = 32'd67211564;
    localparam logic [15:0] HIGH_POWER_MV_RST  = 16'd9000;
    localparam logic [15:0] DEFAULT_MV         = 16'd5000;
    localparam logic [13:0] DEFAULT_MA         = 14'd500;
    localparam logic [15:0] MIN_CONTRACT_MV    = 16'd5000;

    typedef struct packed {
        logic [1:0]  neg_state;
        logic        neg_failed;
        logic        has_contract;
        logic [15:0] contract_mv;
        logic [13:0] contract_ma;
        logic [15:0] requested_mv;
        logic [2:0]  source_pdo_total;
    } t_status;

    typedef struct packed {
        logic [4:0]  rx_type;
        logic [1:0]  rx_revision;
        logic [2:0]  rx_id;
        logic [2:0]  objects_left;
        logic        rx_extended;
        logic [2:0]  object_index;
        logic [2:0]  best_position;
        logic [15:0] best_mv;
        logic [9:0]  best_current_units;
        logic [2:0]  tx_id;
        logic [2:0]  last_rx_id;
        logic        last_rx_id_valid;
        logic        accepted;
        logic [15:0] pending_mv;
        logic [13:0] pending_ma;
        t_status     status;
    } t_state;

    // All results of one input item: up to two transmitted words and the status.
    typedef struct packed {
        logic [1:0]  tx_count;
        logic [15:0] tx_header;
        logic [31:0] tx_object;
        t_status     status;
        logic [1:0]  amp_mode;
    } t_bundle;

    function automatic logic [15:0] make_header(
        input logic [4:0] msg_type,
        input logic [2:0] count,
        input logic [2:0] id
    );
        make_header = {1'b0, count, id, 1'b0, 2'b01, 1'b0, msg_type};
    endfunction

endpackage

// ----- hw/rtl/usb_pd_sink_policy_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_pd_sink_policy_engine
// USB-PD revision 2 sink policy engine working on received message words.
// ----------------------------------------------------------------------------
// The engine accepts one received word per cycle: a message header (op 0),
// a data object (op 1) or a link reset (op 2). The word is fully processed in
// the cycle it is accepted, and every result it causes (an optional
// transmitted header, an optional transmitted data object, and always a
// closing status report with last set) is written as one bundle into a
// two-entry result queue. Results leave that queue one per output
// transaction, so an item gives one to three results; with
// the output always ready, items that cause only a status report flow at one
// per cycle, and input ready drops only when both queue entries hold
// undelivered bundles. A source capabilities message is answered with a
// Request for the highest fixed PDO at or below max_request_mv; Accept, PS_RDY,
// Reject, Wait, Soft_Reset, Get_Sink_Cap and GoodCRC are handled as a sink
// does, other control messages of revision 2 or later get Not_Supported, and
// extended messages are ignored. The configuration port is always ready;
// registers are meant to be written only while the engine is idle. Status
// fields on every result reflect the state after the word that caused it.
// ----------------------------------------------------------------------------
module usb_pd_sink_policy_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received word channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_word,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_tx_word,
    output logic        o_last,
    output logic [1:0]  o_neg_state,
    output logic        o_neg_failed,
    output logic        o_has_contract,
    output logic [15:0] o_contract_mv,
    output logic [13:0] o_contract_ma,
    output logic [15:0] o_requested_mv,
    output logic [2:0]  o_source_pdo_total,
    output logic [1:0]  o_amp_mode,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    usbpd_pkg::t_state  r_state;
    usbpd_pkg::t_state  n_state;
    usbpd_pkg::t_state  rst_state;
    usbpd_pkg::t_bundle n_bundle;
    usbpd_pkg::t_status head_status;
    logic [15:0]        r_max_request_mv;
    logic [31:0]        r_sink_cap_word;
    logic [15:0]        r_high_power_mv;
    logic               q_full;
    logic               in_take;

    assign o_ready     = !q_full;
    assign o_cfg_ready = 1'b1;
    assign in_take     = i_valid && o_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_request_mv <= usbpd_pkg::MAX_REQUEST_MV_RST;
            r_sink_cap_word  <= usbpd_pkg::SINK_CAP_WORD_RST;
            r_high_power_mv  <= usbpd_pkg::HIGH_POWER_MV_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                usbpd_pkg::CFG_MAX_REQUEST_MV: r_max_request_mv <= i_cfg_data[15:0];
                usbpd_pkg::CFG_SINK_CAP_WORD:  r_sink_cap_word  <= i_cfg_data;
                usbpd_pkg::CFG_HIGH_POWER_MV:  r_high_power_mv  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // All message decoding and policy decisions for one word.
    usbpd_step u_step (
        .i_state          (r_state),
        .i_op             (i_op),
        .i_word           (i_word),
        .i_max_request_mv (r_max_request_mv),
        .i_sink_cap_word  (r_sink_cap_word),
        .i_high_power_mv  (r_high_power_mv),
        .o_state          (n_state),
        .o_bundle         (n_bundle)
    );

    // After reset the engine is negotiating at 5 V and 500 mA with nothing pending.
    always_comb begin
        rst_state                    = '0;
        rst_state.status.contract_mv = usbpd_pkg::DEFAULT_MV;
        rst_state.status.contract_ma = usbpd_pkg::DEFAULT_MA;
    end

    // Engine state advances only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rst_state;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Result queue; it also serializes each bundle into single results.
    usbpd_txq u_txq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_take),
        .i_bundle   (n_bundle),
        .o_full     (q_full),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_tx_word  (o_tx_word),
        .o_last     (o_last),
        .o_status   (head_status),
        .o_amp_mode (o_amp_mode)
    );

    assign o_neg_state        = head_status.neg_state;
    assign o_neg_failed       = head_status.neg_failed;
    assign o_has_contract     = head_status.has_contract;
    assign o_contract_mv      = head_status.contract_mv;
    assign o_contract_ma      = head_status.contract_ma;
    assign o_requested_mv     = head_status.requested_mv;
    assign o_source_pdo_total = head_status.source_pdo_total;

    // The closing result of every word is a status report.
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind == usbpd_pkg::KIND_STATUS))
        else $error("last result is not a status report");

    // A transmitted data object is always followed by the status report.
    a_data_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == usbpd_pkg::KIND_DATA) |-> !o_last)
        else $error("data object marked as last result");

    // Input back-pressure only occurs while results are waiting.
    a_stall_has_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no pending results");

    // High amplifier mode is never shown on a result without a contract.
    a_amp_needs_contract: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_amp_mode == usbpd_pkg::AMP_HIGH) |-> o_has_contract)
        else $error("high amplifier mode without a contract");

endmodule

// ----- hw/rtl/usbpd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbpd_step
// Next-state and result logic for one received word of the policy engine.
// ----------------------------------------------------------------------------
module usbpd_step (
    input  usbpd_pkg::t_state  i_state,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_word,
    input  logic [15:0]        i_max_request_mv,
    input  logic [31:0]        i_sink_cap_word,
    input  logic [15:0]        i_high_power_mv,
    output usbpd_pkg::t_state  o_state,
    output usbpd_pkg::t_bundle o_bundle
);

    usbpd_pkg::t_state  n_state;
    usbpd_pkg::t_bundle n_bundle;
    logic               complete;
    logic [2:0]         msg_count;
    logic [2:0]         hdr_count;
    logic [9:0]         pdo_units;
    logic [15:0]        pdo_mv;
    logic [13:0]        req_ma;
    logic [9:0]         req_cu;

    // Fixed PDO voltage is in 50 mV units: x * 50 = x*32 + x*16 + x*2.
    assign pdo_units = i_word[19:10];
    assign pdo_mv    = ({6'b0, pdo_units} << 5) + ({6'b0, pdo_units} << 4)
                     + ({6'b0, pdo_units} << 1);
    assign hdr_count = i_word[14:12];

    always_comb begin
        n_state            = i_state;
        n_bundle           = '0;
        complete           = 1'b0;
        msg_count          = 3'd0;
        req_cu             = 10'd0;
        req_ma             = 14'd0;

        unique case (i_op)
            usbpd_pkg::OP_HEADER: begin
                n_state.rx_type            = i_word[4:0];
                n_state.rx_revision        = i_word[7:6];
                n_state.rx_id              = i_word[11:9];
                n_state.rx_extended        = i_word[15];
                n_state.object_index       = 3'd0;
                n_state.best_position      = 3'd0;
                n_state.best_mv            = 16'd0;
                n_state.best_current_units = 10'd0;
                n_state.objects_left       = 3'd0;
                if (hdr_count <= usbpd_pkg::MAX_OBJECTS) begin
                    if (hdr_count == 3'd0) begin
                        complete = 1'b1;
                    end else begin
                        n_state.objects_left = hdr_count;
                    end
                end
            end
            usbpd_pkg::OP_OBJECT: begin
                if (i_state.objects_left != 3'd0) begin
                    if (i_word[31:30] == 2'b00 && pdo_mv <= i_max_request_mv
                            && pdo_mv > i_state.best_mv) begin
                        n_state.best_position      = i_state.object_index + 3'd1;
                        n_state.best_mv            = pdo_mv;
                        n_state.best_current_units = i_word[9:0];
                    end
                    n_state.object_index = i_state.object_index + 3'd1;
                    n_state.objects_left = i_state.objects_left - 3'd1;
                    if (i_state.objects_left == 3'd1) begin
                        complete  = 1'b1;
                        msg_count = i_state.object_index + 3'd1;
                    end
                end
            end
            usbpd_pkg::OP_LINK_RESET: begin
                n_state.objects_left     = 3'd0;
                n_state.tx_id            = 3'd0;
                n_state.last_rx_id_valid = 1'b0;
                n_state.accepted         = 1'b0;
            end
            default: begin
            end
        endcase

        if (complete && !n_state.rx_extended) begin
            if (msg_count == 3'd0 && n_state.rx_type == usbpd_pkg::CTRL_GOODCRC) begin
                n_state.tx_id = n_state.tx_id + 3'd1;
            end else if (!(n_state.last_rx_id_valid
                           && n_state.rx_id == n_state.last_rx_id)) begin
                n_state.last_rx_id       = n_state.rx_id;
                n_state.last_rx_id_valid = 1'b1;
                if (msg_count != 3'd0) begin
                    if (n_state.rx_type == usbpd_pkg::DATA_SOURCE_CAP) begin
                        if (n_state.best_position == 3'd0) begin
                            n_state.status.neg_state  = usbpd_pkg::NEG_FALLBACK;
                            n_state.status.neg_failed = 1'b1;
                        end else begin
                            req_cu = n_state.best_current_units;
                            req_ma = ({4'b0, req_cu} << 3) + ({4'b0, req_cu} << 1);
                            n_state.pending_mv              = n_state.best_mv;
                            n_state.pending_ma              = req_ma;
                            n_state.accepted                = 1'b0;
                            n_state.status.source_pdo_total = msg_count;
                            n_state.status.requested_mv     = n_state.best_mv;
                            n_bundle.tx_count  = 2'd2;
                            n_bundle.tx_header = usbpd_pkg::make_header(
                                usbpd_pkg::DATA_REQUEST, 3'd1, n_state.tx_id);
                            n_bundle.tx_object = {1'b0, n_state.best_position, 2'b00,
                                                  1'b1, 1'b1, 4'b0000, req_cu, req_cu};
                        end
                    end
                end else begin
                    unique case (n_state.rx_type) inside
                        usbpd_pkg::CTRL_ACCEPT: begin
                            n_state.accepted = 1'b1;
                        end
                        usbpd_pkg::CTRL_PS_RDY: begin
                            if (n_state.accepted
                                    && n_state.pending_mv >= usbpd_pkg::MIN_CONTRACT_MV) begin
                                n_state.status.has_contract = 1'b1;
                                n_state.status.neg_failed   = 1'b0;
                                n_state.status.contract_mv  = n_state.pending_mv;
                                n_state.status.contract_ma  = n_state.pending_ma;
                                n_state.status.neg_state    = usbpd_pkg::NEG_CONTRACT;
                            end
                        end
                        usbpd_pkg::CTRL_REJECT, usbpd_pkg::CTRL_WAIT: begin
                            n_state.status.neg_state  = usbpd_pkg::NEG_FALLBACK;
                            n_state.status.neg_failed = 1'b1;
                        end
                        usbpd_pkg::CTRL_SOFT_RESET: begin
                            n_state.tx_id            = 3'd0;
                            n_state.last_rx_id_valid = 1'b0;
                            n_state.accepted         = 1'b0;
                            n_bundle.tx_count  = 2'd1;
                            n_bundle.tx_header = usbpd_pkg::make_header(
                                usbpd_pkg::CTRL_ACCEPT, 3'd0, 3'd0);
                        end
                        usbpd_pkg::CTRL_GET_SINK_CAP: begin
                            n_bundle.tx_count  = 2'd2;
                            n_bundle.tx_header = usbpd_pkg::make_header(
                                usbpd_pkg::DATA_SINK_CAP, 3'd1, n_state.tx_id);
                            n_bundle.tx_object = i_sink_cap_word;
                        end
                        default: begin
                            if (n_state.rx_revision != 2'd0) begin
                                n_bundle.tx_count  = 2'd1;
                                n_bundle.tx_header = usbpd_pkg::make_header(
                                    usbpd_pkg::CTRL_NOT_SUPPORTED, 3'd0, n_state.tx_id);
                            end
                        end
                    endcase
                end
            end
        end

        n_bundle.status   = n_state.status;
        n_bundle.amp_mode = (n_state.status.has_contract
                             && n_state.status.contract_mv >= i_high_power_mv)
                            ? usbpd_pkg::AMP_HIGH : usbpd_pkg::AMP_NORMAL;
    end

    assign o_state  = n_state;
    assign o_bundle = n_bundle;

endmodule

// ----- hw/rtl/usbpd_txq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbpd_txq
// Two-entry queue of result bundles, sent out one result per transaction.
// ----------------------------------------------------------------------------
module usbpd_txq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  usbpd_pkg::t_bundle i_bundle,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic [31:0]        o_tx_word,
    output logic               o_last,
    output usbpd_pkg::t_status o_status,
    output logic [1:0]         o_amp_mode
);

    usbpd_pkg::t_bundle r_entry [2];
    usbpd_pkg::t_bundle head;
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic [1:0]         r_sub;
    logic               take;
    logic               pop;

    assign head    = r_entry[r_rd_ptr];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_last  = (r_sub == head.tx_count);
    assign take    = o_valid && i_ready;
    assign pop     = take && o_last;

    always_comb begin
        if (r_sub < head.tx_count) begin
            if (r_sub == 2'd0) begin
                o_kind    = usbpd_pkg::KIND_HEADER;
                o_tx_word = {16'd0, head.tx_header};
            end else begin
                o_kind    = usbpd_pkg::KIND_DATA;
                o_tx_word = head.tx_object;
            end
        end else begin
            o_kind    = usbpd_pkg::KIND_STATUS;
            o_tx_word = 32'd0;
        end
    end

    assign o_status   = head.status;
    assign o_amp_mode = head.amp_mode;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 2'd0;
            end else if (take) begin
                r_sub <= r_sub + 2'd1;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- tb/usb_pd_sink_policy_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_pd_sink_policy_engine_test
// Self-checking testbench for the USB-PD sink policy engine.
// ----------------------------------------------------------------------------
// Received PD words are pushed into the engine over its valid/ready input
// channel. A reply predictor inside the bench follows the sink protocol on its
// own: message assembly, PDO selection, message ID handling, contract
// tracking and the replies that a sink transmits. Every accepted result
// transaction is compared field by field against the oldest predicted reply.
// The run starts with a directed walk through a full negotiation and the
// corner cases, then moves through several register settings, each followed
// by a block of random message traffic, with random stalls on both sides in all but one.
// ----------------------------------------------------------------------------
module usb_pd_sink_policy_engine_test;

    // Op code 3 is not defined; the engine must ignore it.
    localparam logic [1:0] OP_NOISE = 2'd3;
    // Register index with no register behind it.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;
    // Header revision field value that stands for PD revision 2.0.
    localparam logic [1:0] REV_2 = 2'd1;

    localparam int PHASE_ITEMS    = 52;
    localparam int RANDOM_PHASES  = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    // One result transaction as the engine presents it.
    typedef struct packed {
        logic [1:0]          kind;
        logic [31:0]         tx_word;
        logic                last;
        usbpd_pkg::t_status  status;
        logic [1:0]          amp_mode;
    } t_pd_result;

    // ------------------------------------------------------------------------
    // Reply predictor and scoreboard.
    // ------------------------------------------------------------------------
    class pd_reply_predictor;
        // Register copies.
        logic [15:0] max_request_mv;
        logic [31:0] sink_cap_word;
        logic [15:0] high_power_mv;
        // Message being assembled.
        logic [4:0]  msg_type;
        logic [1:0]  msg_rev;
        logic [2:0]  msg_id;
        logic [2:0]  objs_due;
        logic        msg_ext;
        logic [2:0]  obj_count;
        logic [2:0]  best_pos;
        logic [15:0] best_mv;
        logic [9:0]  best_units;
        // Link and contract bookkeeping.
        logic [2:0]  tx_msg_id;
        logic [2:0]  seen_id;
        logic        seen_id_valid;
        logic        accept_seen;
        logic [15:0] pend_mv;
        logic [13:0] pend_ma;
        usbpd_pkg::t_status status;
        // Words the engine transmits for the current item.
        logic [1:0]  out_kind[$];
        logic [31:0] out_word[$];
        t_pd_result  due_replies[$];
        int errors;
        int checked;
        int requests;
        int contracts;

        function new();
            max_request_mv = usbpd_pkg::MAX_REQUEST_MV_RST;
            sink_cap_word  = usbpd_pkg::SINK_CAP_WORD_RST;
            high_power_mv  = usbpd_pkg::HIGH_POWER_MV_RST;
            msg_type = '0; msg_rev = '0; msg_id = '0; objs_due = '0; msg_ext = 1'b0;
            obj_count = '0; best_pos = '0; best_mv = '0; best_units = '0;
            tx_msg_id = '0; seen_id = '0; seen_id_valid = 1'b0; accept_seen = 1'b0;
            pend_mv = '0; pend_ma = '0;
            status = '0;
            status.neg_state   = usbpd_pkg::NEG_NEGOTIATING;
            status.contract_mv = usbpd_pkg::DEFAULT_MV;
            status.contract_ma = usbpd_pkg::DEFAULT_MA;
            errors = 0; checked = 0; requests = 0; contracts = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [31:0] data);
            case (index)
                usbpd_pkg::CFG_MAX_REQUEST_MV: max_request_mv = data[15:0];
                usbpd_pkg::CFG_SINK_CAP_WORD:  sink_cap_word  = data;
                usbpd_pkg::CFG_HIGH_POWER_MV:  high_power_mv  = data[15:0];
                default: ;
            endcase
        endfunction

        function void queue_message(logic [4:0] t, logic [2:0] n, logic [31:0] obj,
                                    logic [2:0] id);
            out_kind.push_back(usbpd_pkg::KIND_HEADER);
            out_word.push_back(32'(t) | (32'd1 << 6) | (32'(id) << 9) | (32'(n) << 12));
            if (n != 0) begin
                out_kind.push_back(usbpd_pkg::KIND_DATA);
                out_word.push_back(obj);
            end
        endfunction

        // Acts on a message whose last object (or header alone) just arrived.
        function void finish_message(logic [2:0] n);
            logic [9:0]  cu;
            logic [31:0] req;
            if (msg_ext)
                return;
            if (n == 0 && msg_type == usbpd_pkg::CTRL_GOODCRC) begin
                tx_msg_id = tx_msg_id + 3'd1;
                return;
            end
            if (seen_id_valid && msg_id == seen_id)
                return;
            seen_id = msg_id;
            seen_id_valid = 1'b1;
            if (n != 0) begin
                if (msg_type == usbpd_pkg::DATA_SOURCE_CAP) begin
                    if (best_pos == 0) begin
                        status.neg_state  = usbpd_pkg::NEG_FALLBACK;
                        status.neg_failed = 1'b1;
                    end else begin
                        cu  = best_units;
                        req = {1'b0, best_pos, 2'b00, 2'b11, 4'b0000, cu, cu};
                        pend_mv = best_mv;
                        pend_ma = cu * 14'd10;
                        accept_seen = 1'b0;
                        status.source_pdo_total = n;
                        status.requested_mv = best_mv;
                        queue_message(usbpd_pkg::DATA_REQUEST, 3'd1, req, tx_msg_id);
                        requests++;
                    end
                end
                return;
            end
            case (msg_type)
                usbpd_pkg::CTRL_ACCEPT: accept_seen = 1'b1;
                usbpd_pkg::CTRL_PS_RDY: begin
                    if (accept_seen && pend_mv >= usbpd_pkg::MIN_CONTRACT_MV) begin
                        status.has_contract = 1'b1;
                        status.neg_failed   = 1'b0;
                        status.contract_mv  = pend_mv;
                        status.contract_ma  = pend_ma;
                        status.neg_state    = usbpd_pkg::NEG_CONTRACT;
                        contracts++;
                    end
                end
                usbpd_pkg::CTRL_REJECT, usbpd_pkg::CTRL_WAIT: begin
                    status.neg_state  = usbpd_pkg::NEG_FALLBACK;
                    status.neg_failed = 1'b1;
                end
                usbpd_pkg::CTRL_SOFT_RESET: begin
                    tx_msg_id = '0;
                    seen_id_valid = 1'b0;
                    accept_seen = 1'b0;
                    queue_message(usbpd_pkg::CTRL_ACCEPT, 3'd0, 32'd0, 3'd0);
                end
                usbpd_pkg::CTRL_GET_SINK_CAP:
                    queue_message(usbpd_pkg::DATA_SINK_CAP, 3'd1, sink_cap_word, tx_msg_id);
                default: begin
                    if (msg_rev >= 2'd1)
                        queue_message(usbpd_pkg::CTRL_NOT_SUPPORTED, 3'd0, 32'd0, tx_msg_id);
                end
            endcase
        endfunction

        // Predicts every result of one accepted input word.
        function void take_word(logic [1:0] op, logic [31:0] w);
            logic [15:0] volt;
            logic [2:0]  n;
            t_pd_result  r;
            out_kind.delete();
            out_word.delete();
            case (op)
                usbpd_pkg::OP_HEADER: begin
                    n = w[14:12];
                    objs_due = '0;
                    msg_type = w[4:0];
                    msg_rev  = w[7:6];
                    msg_id   = w[11:9];
                    msg_ext  = w[15];
                    obj_count = '0;
                    best_pos = '0;
                    best_mv = '0;
                    best_units = '0;
                    if (n == 0)
                        finish_message(3'd0);
                    else if (n <= usbpd_pkg::MAX_OBJECTS)
                        objs_due = n;
                end
                usbpd_pkg::OP_OBJECT: begin
                    if (objs_due != 0) begin
                        // Only fixed supply PDOs are candidates.
                        if (w[31:30] == 2'b00) begin
                            volt = w[19:10] * 16'd50;
                            if (volt <= max_request_mv && volt > best_mv) begin
                                best_pos   = obj_count + 3'd1;
                                best_mv    = volt;
                                best_units = w[9:0];
                            end
                        end
                        obj_count = obj_count + 3'd1;
                        objs_due  = objs_due - 3'd1;
                        if (objs_due == 0)
                            finish_message(obj_count);
                    end
                end
                usbpd_pkg::OP_LINK_RESET: begin
                    objs_due = '0;
                    tx_msg_id = '0;
                    seen_id_valid = 1'b0;
                    accept_seen = 1'b0;
                end
                default: ;
            endcase
            out_kind.push_back(usbpd_pkg::KIND_STATUS);
            out_word.push_back(32'd0);
            for (int i = 0; i < out_kind.size(); i++) begin
                r.kind     = out_kind[i];
                r.tx_word  = out_word[i];
                r.last     = (i == out_kind.size() - 1);
                r.status   = status;
                r.amp_mode = (status.has_contract && status.contract_mv >= high_power_mv)
                             ? usbpd_pkg::AMP_HIGH : usbpd_pkg::AMP_NORMAL;
                due_replies.push_back(r);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s: got %0h, predicted %0h", name, got_v, want_v));
        endtask

        task match_reply(t_pd_result got);
            t_pd_result want;
            if (due_replies.size() == 0) begin
                report($sformatf("result with nothing pending: kind %0h word %0h",
                                 got.kind, got.tx_word));
                return;
            end
            want = due_replies.pop_front();
            checked++;
            check_field("kind", 32'(got.kind), 32'(want.kind));
            check_field("tx_word", got.tx_word, want.tx_word);
            check_field("last", 32'(got.last), 32'(want.last));
            check_field("neg_state", 32'(got.status.neg_state),
                        32'(want.status.neg_state));
            check_field("neg_failed", 32'(got.status.neg_failed),
                        32'(want.status.neg_failed));
            check_field("has_contract", 32'(got.status.has_contract),
                        32'(want.status.has_contract));
            check_field("contract_mv", 32'(got.status.contract_mv),
                        32'(want.status.contract_mv));
            check_field("contract_ma", 32'(got.status.contract_ma),
                        32'(want.status.contract_ma));
            check_field("requested_mv", 32'(got.status.requested_mv),
                        32'(want.status.requested_mv));
            check_field("source_pdo_total", 32'(got.status.source_pdo_total),
                        32'(want.status.source_pdo_total));
            check_field("amp_mode", 32'(got.amp_mode), 32'(want.amp_mode));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = usbpd_pkg::OP_HEADER;
    logic [31:0] i_word = 32'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [31:0] o_tx_word;
    logic        o_last;
    logic [1:0]  o_neg_state;
    logic        o_neg_failed;
    logic        o_has_contract;
    logic [15:0] o_contract_mv;
    logic [13:0] o_contract_ma;
    logic [15:0] o_requested_mv;
    logic [2:0]  o_source_pdo_total;
    logic [1:0]  o_amp_mode;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = usbpd_pkg::CFG_MAX_REQUEST_MV;
    logic [31:0] i_cfg_data = 32'd0;

    pd_reply_predictor model;

    // Stall rates of the two sides, in percent.
    int src_idle_pct  = 16;
    int sink_idle_pct = 16;
    int words_sent    = 0;
    int useful_items  = 0;
    int settings_used = 1;
    int stall_cycles  = 0;
    logic [2:0]  rx_seq = 3'd0;
    logic [31:0] last_pdo = 32'd0;

    usb_pd_sink_policy_engine dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_op               (i_op),
        .i_word             (i_word),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_tx_word          (o_tx_word),
        .o_last             (o_last),
        .o_neg_state        (o_neg_state),
        .o_neg_failed       (o_neg_failed),
        .o_has_contract     (o_has_contract),
        .o_contract_mv      (o_contract_mv),
        .o_contract_ma      (o_contract_ma),
        .o_requested_mv     (o_requested_mv),
        .o_source_pdo_total (o_source_pdo_total),
        .o_amp_mode         (o_amp_mode),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls at random. All sampling below happens right after
    // the rising edge, so it sees the values that the edge itself acted on.
    always @(posedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // Every result transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_pd_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.kind                    = o_kind;
            got.tx_word                 = o_tx_word;
            got.last                    = o_last;
            got.status.neg_state        = o_neg_state;
            got.status.neg_failed       = o_neg_failed;
            got.status.has_contract     = o_has_contract;
            got.status.contract_mv      = o_contract_mv;
            got.status.contract_ma      = o_contract_ma;
            got.status.requested_mv     = o_requested_mv;
            got.status.source_pdo_total = o_source_pdo_total;
            got.amp_mode                = o_amp_mode;
            model.match_reply(got);
        end
    end

    // The watchdog ends a run in which no channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Pushes one word and returns once the engine has taken it. Valid is only
    // dropped when a random gap is inserted, so back-to-back items keep it high.
    task automatic drive_item(input logic [1:0] op, input logic [31:0] w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_word  <= w;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        model.take_word(op, w);
        words_sent++;
        if (op != OP_NOISE)
            useful_items++;
    endtask

    // Header word with random filler in the bits the engine does not decode.
    function automatic logic [31:0] header_word(logic [4:0] t, logic [2:0] n, logic [2:0] id,
                                                logic [1:0] rev, logic ext);
        logic [31:0] h;
        h = $urandom;
        h[4:0]   = t;
        h[7:6]   = rev;
        h[11:9]  = id;
        h[14:12] = n;
        h[15]    = ext;
        return h;
    endfunction

    // Fixed supply PDO: voltage in 50 mV units, current in 10 mA units.
    function automatic logic [31:0] fixed_pdo(logic [9:0] units_v, logic [9:0] units_i);
        logic [31:0] p;
        p = $urandom;
        p[31:30] = 2'b00;
        p[19:10] = units_v;
        p[9:0]   = units_i;
        return p;
    endfunction

    // Mostly fixed PDOs at or below the current voltage limit, some at any voltage, some of
    // other supply types, and now and then a repeat of the previous object.
    function automatic logic [31:0] random_pdo();
        int pick;
        int limit_units;
        pick = $urandom_range(0, 99);
        limit_units = model.max_request_mv / 50;
        if (limit_units > 1023)
            limit_units = 1023;
        if (pick < 10)
            last_pdo = $urandom;
        else if (pick < 20)
            last_pdo = last_pdo;
        else if (pick < 65 && limit_units > 0)
            last_pdo = fixed_pdo(10'($urandom_range(1, limit_units)), 10'($urandom));
        else
            last_pdo = fixed_pdo(10'($urandom_range(0, 1023)), 10'($urandom));
        return last_pdo;
    endfunction

    // Message IDs mostly advance; one in ten repeats the previous one.
    function automatic logic [2:0] next_id();
        if ($urandom_range(0, 9) != 0)
            rx_seq = rx_seq + 3'd1;
        return rx_seq;
    endfunction

    task automatic send_header(input logic [4:0] t, input logic [2:0] n, input logic [2:0] id,
                               input logic [1:0] rev, input logic ext);
        drive_item(usbpd_pkg::OP_HEADER, header_word(t, n, id, rev, ext));
    endtask

    task automatic send_control(input logic [4:0] t, input logic [2:0] id);
        send_header(t, 3'd0, id, REV_2, 1'b0);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        model.write_register(index, data);
    endtask

    // Writes all three registers back to back; 16-bit registers may carry
    // garbage in their upper half, which the engine must drop.
    task automatic apply_settings(input logic [31:0] mv, input logic [31:0] cap,
                                  input logic [31:0] hp, input bit touch_unused);
        write_register(usbpd_pkg::CFG_MAX_REQUEST_MV, mv);
        write_register(usbpd_pkg::CFG_SINK_CAP_WORD, cap);
        write_register(usbpd_pkg::CFG_HIGH_POWER_MV, hp);
        if (touch_unused)
            write_register(CFG_UNUSED_INDEX, $urandom);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Waits until every predicted result has come out, then lets the engine
    // settle before registers are touched or the run ends.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (model.due_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random message exchange. The largest share of traffic is well-formed negotiation so
    // the contract states are reached; the rest is other messages, truncated
    // messages, link resets and noise.
    task automatic random_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            n = $urandom_range(1, 7);
            send_header(usbpd_pkg::DATA_SOURCE_CAP, 3'(n), next_id(), REV_2, 1'b0);
            repeat (n) drive_item(usbpd_pkg::OP_OBJECT, random_pdo());
            if ($urandom_range(0, 99) < 70)
                send_control(usbpd_pkg::CTRL_GOODCRC, 3'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_control(usbpd_pkg::CTRL_ACCEPT, next_id());
                if ($urandom_range(0, 99) < 85)
                    send_control(usbpd_pkg::CTRL_PS_RDY, next_id());
            end else if (pick < 80) begin
                send_control(usbpd_pkg::CTRL_REJECT, next_id());
            end else if (pick < 90) begin
                send_control(usbpd_pkg::CTRL_WAIT, next_id());
            end else begin
                send_control(usbpd_pkg::CTRL_PS_RDY, next_id());
            end
        end else if (pick < 48) begin
            send_header(5'($urandom_range(0, 31)), 3'd0, next_id(),
                        2'($urandom_range(0, 3)), 1'b0);
        end else if (pick < 56) begin
            send_control(usbpd_pkg::CTRL_GET_SINK_CAP, next_id());
        end else if (pick < 61) begin
            send_control(usbpd_pkg::CTRL_SOFT_RESET, next_id());
        end else if (pick < 65) begin
            send_control(usbpd_pkg::CTRL_GOODCRC, 3'($urandom));
        end else if (pick < 73) begin
            // Data message of any type with arbitrary objects.
            n = $urandom_range(1, 7);
            send_header(5'($urandom_range(0, 31)), 3'(n), next_id(),
                        2'($urandom_range(0, 3)), 1'b0);
            repeat (n) drive_item(usbpd_pkg::OP_OBJECT, $urandom);
        end else if (pick < 80) begin
            // Extended message, consumed without effect.
            n = $urandom_range(0, 7);
            send_header(5'($urandom_range(0, 31)), 3'(n), 3'($urandom),
                        2'($urandom_range(0, 3)), 1'b1);
            repeat (n) drive_item(usbpd_pkg::OP_OBJECT, $urandom);
        end else if (pick < 88) begin
            // Capabilities cut short, by the next header or by a link reset.
            n = $urandom_range(2, 7);
            send_header(usbpd_pkg::DATA_SOURCE_CAP, 3'(n), next_id(), REV_2, 1'b0);
            repeat ($urandom_range(1, n - 1)) drive_item(usbpd_pkg::OP_OBJECT, random_pdo());
            if ($urandom_range(0, 99) < 30)
                drive_item(usbpd_pkg::OP_LINK_RESET, $urandom);
        end else if (pick < 93) begin
            drive_item(usbpd_pkg::OP_LINK_RESET, $urandom);
        end else begin
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
                drive_item(OP_NOISE, $urandom);
            end else if (pick == 1 && model.objs_due == 0) begin
                // A stray object is ignored, so it does not count as stimulus.
                drive_item(usbpd_pkg::OP_OBJECT, $urandom);
                useful_items--;
            end else begin
                drive_item(usbpd_pkg::OP_HEADER, $urandom);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        int target;
        logic [31:0] garbage;
        model = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset register values (20 V limit).
        // An undefined op and a stray object only produce a status report.
        drive_item(OP_NOISE, 32'hFFFF_FFFF);
        drive_item(usbpd_pkg::OP_OBJECT, 32'hFFFF_FFFF);
        // Capabilities: 5 V, 9 V, a non-fixed supply object, then 20 V which sits
        // exactly on the limit and carries the largest current field.
        send_header(usbpd_pkg::DATA_SOURCE_CAP, 3'd4, 3'd0, REV_2, 1'b0);
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'd100, 10'd300));
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'd180, 10'd300));
        drive_item(usbpd_pkg::OP_OBJECT, 32'hFFFF_FFFF);
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'd400, 10'h3FF));
        // GoodCRC for the Request, then Accept and PS_RDY form the contract.
        send_control(usbpd_pkg::CTRL_GOODCRC, 3'd0);
        send_control(usbpd_pkg::CTRL_ACCEPT, 3'd1);
        send_control(usbpd_pkg::CTRL_PS_RDY, 3'd2);
        // The same ID again is a retransmission and must be dropped.
        send_control(usbpd_pkg::CTRL_PS_RDY, 3'd2);
        send_control(usbpd_pkg::CTRL_GET_SINK_CAP, 3'd3);
        // Unknown control type: answered at revision 3.0, silent at 1.0.
        send_header(5'h1F, 3'd0, 3'd4, 2'd2, 1'b0);
        send_header(5'd7, 3'd0, 3'd5, 2'd0, 1'b0);
        send_control(usbpd_pkg::CTRL_WAIT, 3'd6);
        send_control(usbpd_pkg::CTRL_REJECT, 3'd7);
        // Extended message with objects: ignored altogether.
        send_header(usbpd_pkg::DATA_SOURCE_CAP, 3'd2, 3'd0, REV_2, 1'b1);
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'd100, 10'd100));
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'd100, 10'd100));
        // A data message that is not capabilities is recorded but not answered.
        send_header(5'd3, 3'd1, 3'd1, REV_2, 1'b0);
        drive_item(usbpd_pkg::OP_OBJECT, 32'd0);
        // Capabilities cut short by a new header; the new one only offers a
        // voltage above the limit, so negotiation ends in fallback.
        send_header(usbpd_pkg::DATA_SOURCE_CAP, 3'd3, 3'd2, REV_2, 1'b0);
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'd100, 10'd0));
        send_header(usbpd_pkg::DATA_SOURCE_CAP, 3'd1, 3'd3, REV_2, 1'b0);
        drive_item(usbpd_pkg::OP_OBJECT, fixed_pdo(10'h3FF, 10'd0));
        send_control(usbpd_pkg::CTRL_SOFT_RESET, 3'd4);
        drive_item(usbpd_pkg::OP_LINK_RESET, 32'd0);
        wait_idle();

        // Random phases, each at its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            garbage = $urandom & 32'hFFFF_0000;
            case (phase)
                0: apply_settings(32'd51150, 32'hFFFF_FFFF, 32'd51150, 1'b0);
                1: apply_settings(32'd0, 32'd0, 32'd0, 1'b0);
                2: apply_settings(32'h0000_FFFF, $urandom, 32'd5000, 1'b0);
                default: apply_settings(garbage | $urandom_range(5000, 51150), $urandom,
                                        garbage | $urandom_range(0, 51150), phase == 4);
            endcase
            // One phase runs with neither side idling at all.
            src_idle_pct  = (phase == 1) ? 0 : 16;
            sink_idle_pct = (phase == 1) ? 0 : 16;
            target = useful_items + PHASE_ITEMS;
            while (useful_items < target)
                random_sequence();
            wait_idle();
        end

        $display("Run covered %0d input transactions (%0d counted) and %0d results",
                 words_sent, useful_items, model.checked);
        $display("over %0d register settings, with %0d Requests, %0d contracts, %0d errors.",
                 settings_used, model.requests, model.contracts, model.errors);
        if (model.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- usb_pd_sink_policy_engine.f -----
hw/rtl/usbpd_pkg.sv
hw/rtl/usbpd_step.sv
hw/rtl/usbpd_txq.sv
hw/rtl/usb_pd_sink_policy_engine.sv
tb/usb_pd_sink_policy_engine_test.sv
